[sv/wbps_pkg.sv]
// ----------------------------------------------------------------------------
// Wildcard byte pattern search: shared definitions
// Widths, register indexes and the match setup that is handed to every
// window cell.
// ----------------------------------------------------------------------------
package wbps_pkg;

  // Fixed field widths.
  localparam int unsigned DataW        = 8;
  localparam int unsigned AddrW        = 64;
  localparam int unsigned PatternBytes = 16;
  localparam int unsigned PatternW     = PatternBytes * DataW;
  localparam int unsigned WildW        = PatternBytes * 2;
  localparam int unsigned LenRawW      = 5;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 64;

  // Default for the largest pattern the block has window cells for.
  localparam int unsigned MaxPatternBytesDefault = 16;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgBaseAddress   = 3'd0,
    CfgPatternLow    = 3'd1,
    CfgPatternHigh   = 3'd2,
    CfgWildcardMask  = 3'd3,
    CfgPatternLength = 3'd4
  } cfg_idx_e;

  // Match setup seen by every window cell. The length is already clamped.
  typedef struct packed {
    logic [PatternW-1:0] pattern;
    logic [WildW-1:0]    wild;
    logic [LenRawW-1:0]  len;
  } match_cfg_t;

endpackage

[sv/wbps_cell.sv]
// ----------------------------------------------------------------------------
// Wildcard byte pattern search: window cell
// Holds one byte of the sliding window, passes it on to the next cell when
// the window shifts, and compares the byte it is about to take against the
// pattern byte that lines up with its place for the current length.
// ----------------------------------------------------------------------------
module wbps_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic                        clk_i,
  input  logic                        shift_i,
  input  logic [wbps_pkg::DataW-1:0]  byte_i,
  input  wbps_pkg::match_cfg_t        cfg_i,
  output logic [wbps_pkg::DataW-1:0]  byte_o,
  output logic                        hit_o
);

  logic [wbps_pkg::DataW-1:0]   byte_q;
  logic [wbps_pkg::LenRawW-1:0] pos;
  logic [3:0]                   sel;
  logic                         active;
  logic [wbps_pkg::DataW-1:0]   pat_byte;
  logic [wbps_pkg::DataW-1:0]   cmp_mask;

  // Window byte; it moves one cell further for every byte searched.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;

  // Cell Idx compares the byte Idx places behind the newest, which lines up
  // with pattern byte len-1-Idx when it lies inside the pattern.
  assign active = cfg_i.len > wbps_pkg::LenRawW'(Idx);
  assign pos    = cfg_i.len - wbps_pkg::LenRawW'(Idx) - wbps_pkg::LenRawW'(1);
  assign sel    = pos[3:0];

  // Select the pattern byte and drop wildcard nibbles from the compare.
  always_comb begin
    pat_byte = cfg_i.pattern[{sel, 3'b000} +: wbps_pkg::DataW];
    cmp_mask = {{4{~cfg_i.wild[{sel, 1'b1}]}}, {4{~cfg_i.wild[{sel, 1'b0}]}}};
  end

  assign hit_o = !active || (((byte_i ^ pat_byte) & cmp_mask) == '0);

endmodule

[sv/wildcard_byte_pattern_search_core.sv]
// ----------------------------------------------------------------------------
// Wildcard byte pattern search core
// Scans a byte stream for the first match of a nibble-wildcard pattern and
// reports its address, or reports no match at the region's last byte.
// ----------------------------------------------------------------------------
// Usage:
// Bytes of a memory region enter on the s_axis channel, one item per byte,
// with s_axis_tlast_i on the region's final byte. The pattern, wildcard
// mask, length and base address are set through the cfg channel, which is
// always ready; the user must make writes while no byte is in flight (not enforced).
// For each region at most one item leaves on m_axis: tuser is 1 with the
// address of the first matching byte in tdata, or tuser is 0 with a zero
// address when the region ended without a match. Bytes after a match are
// swallowed until the last byte, which re-arms the search.
// The result of a byte is registered and is on m_axis in the cycle after
// that byte is taken. Throughput is one byte per cycle unless the output
// stalls; the cells compare all pattern bytes in parallel as the window shifts.
// If the receiver stalls, the result waits in the output register and
// s_axis_tready_o is held low while that register is full and not being
// taken, so no further byte is accepted until the result drains.
// Reset clears the registers to base 0, pattern 0, no wildcards, length 1
// and starts a fresh region.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_search_core #(
  parameter int unsigned MaxPatternBytes = wbps_pkg::MaxPatternBytesDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input items: tdata = data_byte[7:0]; tlast = last_byte
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [wbps_pkg::DataW-1:0]     s_axis_tdata_i,
  input  logic                           s_axis_tlast_i,
  // Result items: tdata = match_address[63:0]; tuser = match_found[0]
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [wbps_pkg::AddrW-1:0]     m_axis_tdata_o,
  output logic [0:0]                     m_axis_tuser_o,
  // Configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [wbps_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [wbps_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned WinDepth =
    (MaxPatternBytes < wbps_pkg::PatternBytes) ? MaxPatternBytes : wbps_pkg::PatternBytes;
  localparam int unsigned FillW = $clog2(WinDepth + 1);
  localparam logic [wbps_pkg::LenRawW-1:0] WinDepthLen = wbps_pkg::LenRawW'(WinDepth);

  // Configuration registers.
  logic [wbps_pkg::AddrW-1:0]    base_q;
  logic [wbps_pkg::PatternW-1:0] pattern_q;
  logic [wbps_pkg::WildW-1:0]    wild_q;
  logic [wbps_pkg::LenRawW-1:0]  plen_q;

  // Search state.
  logic [FillW-1:0]              fill_q, fill_d, fill_inc;
  logic [wbps_pkg::AddrW-1:0]    offset_q, offset_d;
  logic                          reported_q, reported_d;

  // Output register.
  logic                          out_valid_q, out_valid_d;
  logic                          out_found_q, out_found_d;
  logic [wbps_pkg::AddrW-1:0]    out_addr_q, out_addr_d;

  logic                          in_fire, out_fire, cfg_fire;
  logic                          shift;
  logic [wbps_pkg::LenRawW-1:0]  len_eff;
  logic [FillW-1:0]              len_fill;
  wbps_pkg::match_cfg_t          mcfg;
  logic [WinDepth-1:0]           hits;
  logic [wbps_pkg::DataW-1:0]    chain [WinDepth+1];
  logic                          match;
  logic [wbps_pkg::AddrW-1:0]    match_addr;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  // Register writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q    <= '0;
      pattern_q <= '0;
      wild_q    <= '0;
      plen_q    <= wbps_pkg::LenRawW'(1);
    end else if (cfg_fire) begin
      unique case (wbps_pkg::cfg_idx_e'(cfg_index_i))
        wbps_pkg::CfgBaseAddress:   base_q <= cfg_data_i;
        wbps_pkg::CfgPatternLow:    pattern_q[63:0] <= cfg_data_i;
        wbps_pkg::CfgPatternHigh:   pattern_q[127:64] <= cfg_data_i;
        wbps_pkg::CfgWildcardMask:  wild_q <= cfg_data_i[wbps_pkg::WildW-1:0];
        wbps_pkg::CfgPatternLength: plen_q <= cfg_data_i[wbps_pkg::LenRawW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the length: zero acts as one, and it never exceeds the window.
  always_comb begin
    if (plen_q == '0) begin
      len_eff = wbps_pkg::LenRawW'(1);
    end else if (plen_q > WinDepthLen) begin
      len_eff = WinDepthLen;
    end else begin
      len_eff = plen_q;
    end
  end

  assign len_fill     = len_eff[FillW-1:0];
  assign mcfg.pattern = pattern_q;
  assign mcfg.wild    = wild_q;
  assign mcfg.len     = len_eff;

  // Handshakes: a byte is taken whenever the output slot is free or drains.
  assign out_fire        = out_valid_q && m_axis_tready_i;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign shift           = in_fire && !reported_q;

  // Row of window cells, newest byte in cell 0.
  assign chain[0] = s_axis_tdata_i;
  for (genvar k = 0; k < WinDepth; k++) begin : g_cell
    wbps_cell #(
      .Idx(k)
    ) u_cell (
      .clk_i  (clk_i),
      .shift_i(shift),
      .byte_i (chain[k]),
      .cfg_i  (mcfg),
      .byte_o (chain[k+1]),
      .hit_o  (hits[k])
    );
  end

  // Match on the window as it stands after this byte.
  assign fill_inc   = (fill_q == FillW'(WinDepth)) ? fill_q : fill_q + FillW'(1);
  assign match      = (fill_inc >= len_fill) && (&hits);
  assign match_addr = base_q + offset_q - (wbps_pkg::AddrW'(len_eff) - 64'd1);

  // Per-item control: track the region and build the result.
  always_comb begin
    fill_d      = fill_q;
    offset_d    = offset_q;
    reported_d  = reported_q;
    out_valid_d = out_valid_q && !out_fire;
    out_found_d = out_found_q;
    out_addr_d  = out_addr_q;
    if (in_fire) begin
      if (reported_q) begin
        if (s_axis_tlast_i) begin
          fill_d     = '0;
          offset_d   = '0;
          reported_d = 1'b0;
        end
      end else begin
        fill_d   = fill_inc;
        offset_d = offset_q + 64'd1;
        if (match) begin
          out_valid_d = 1'b1;
          out_found_d = 1'b1;
          out_addr_d  = match_addr;
          reported_d  = !s_axis_tlast_i;
        end else if (s_axis_tlast_i) begin
          out_valid_d = 1'b1;
          out_found_d = 1'b0;
          out_addr_d  = '0;
        end
        if (s_axis_tlast_i) begin
          fill_d   = '0;
          offset_d = '0;
        end
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      offset_q    <= '0;
      reported_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      offset_q    <= offset_d;
      reported_q  <= reported_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    out_found_q <= out_found_d;
    out_addr_q  <= out_addr_d;
  end

  assign m_axis_tvalid_o   = out_valid_q;
  assign m_axis_tdata_o    = out_addr_q;
  assign m_axis_tuser_o[0] = out_found_q;

endmodule
